[hdl/rmw_pkg.sv]
// shared types, widths and helpers of the atomic read-modify-write unit
package rmw_pkg;

  localparam int CMD_W  = 4;
  localparam int SIZE_W = 2;
  localparam int ADDR_W = 13;
  localparam int DATA_W = 64;
  localparam int OFS_W  = 3;                 // byte offset inside a word
  localparam int WIDX_W = ADDR_W - OFS_W;    // word index before wrapping

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD  = 4'd0,
    CMD_STORE = 4'd1,
    CMD_XCHG  = 4'd2,
    CMD_CAS   = 4'd3,
    CMD_ADD   = 4'd4,
    CMD_SUB   = 4'd5,
    CMD_AND   = 4'd6,
    CMD_OR    = 4'd7,
    CMD_XOR   = 4'd8,
    CMD_NAND  = 4'd9
  } rmw_cmd_t;

  typedef enum logic [SIZE_W-1:0] {
    SIZE_B1 = 2'd0,
    SIZE_B2 = 2'd1,
    SIZE_B4 = 2'd2,
    SIZE_B8 = 2'd3
  } rmw_size_t;

  // outcome of one read-modify-write on a word
  typedef struct packed {
    logic [DATA_W-1:0] old_value;
    logic [DATA_W-1:0] new_word;
    logic              write;
    logic              success;
  } rmw_alu_res_t;

  function automatic logic [DATA_W-1:0] size_mask(input logic [SIZE_W-1:0] size_code);
    logic [DATA_W-1:0] m;
    unique case (rmw_size_t'(size_code))
      SIZE_B1: m = DATA_W'(64'h0000_0000_0000_00ff);
      SIZE_B2: m = DATA_W'(64'h0000_0000_0000_ffff);
      SIZE_B4: m = DATA_W'(64'h0000_0000_ffff_ffff);
      default: m = {DATA_W{1'b1}};
    endcase
    return m;
  endfunction

endpackage

[hdl/rmw_if.sv]
// request and response channel interfaces of the atomic read-modify-write unit
interface rmw_req_if;
  import rmw_pkg::*;

  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [SIZE_W-1:0] size_code;
  logic [ADDR_W-1:0] byte_address;
  logic [DATA_W-1:0] operand_value;
  logic [DATA_W-1:0] expected_value;

  modport source (
    output valid, command, size_code, byte_address, operand_value, expected_value,
    input  ready
  );
  modport sink (
    input  valid, command, size_code, byte_address, operand_value, expected_value,
    output ready
  );
endinterface

interface rmw_rsp_if;
  import rmw_pkg::*;

  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] old_value;
  logic              success;

  modport source (
    output valid, old_value, success,
    input  ready
  );
  modport sink (
    input  valid, old_value, success,
    output ready
  );
endinterface

[hdl/rmw_mem.sv]
// word store: one write port, one read port with registered read data
module rmw_mem #(
  parameter int DEPTH  = 1024,
  parameter int WIDTH  = 64,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[hdl/rmw_alu.sv]
// lane extract, command evaluation and word merge for one atomic access
module rmw_alu (
  input  logic [rmw_pkg::DATA_W-1:0] word,
  input  logic [rmw_pkg::CMD_W-1:0]  command,
  input  logic [rmw_pkg::SIZE_W-1:0] size_code,
  input  logic [rmw_pkg::OFS_W-1:0]  offset,
  input  logic [rmw_pkg::DATA_W-1:0] operand_value,
  input  logic [rmw_pkg::DATA_W-1:0] expected_value,
  output rmw_pkg::rmw_alu_res_t      res
);
  import rmw_pkg::*;

  logic [DATA_W-1:0] mask;
  logic [5:0]        shamt;
  logic [DATA_W-1:0] old_val;
  logic [DATA_W-1:0] opnd;
  logic [DATA_W-1:0] expct;
  logic [DATA_W-1:0] new_val;
  logic              write;
  logic              ok;

  always_comb begin
    mask    = size_mask(size_code);
    shamt   = {offset, 3'b000};
    old_val = (word >> shamt) & mask;
    opnd    = operand_value & mask;
    expct   = expected_value & mask;
    new_val = old_val;
    write   = 1'b1;
    ok      = 1'b1;
    unique case (rmw_cmd_t'(command))
      CMD_STORE, CMD_XCHG: new_val = opnd;
      CMD_CAS: begin
        new_val = opnd;
        ok      = (old_val == expct);
        write   = ok;
      end
      CMD_ADD:  new_val = old_val + opnd;
      CMD_SUB:  new_val = old_val - opnd;
      CMD_AND:  new_val = old_val & opnd;
      CMD_OR:   new_val = old_val | opnd;
      CMD_XOR:  new_val = old_val ^ opnd;
      CMD_NAND: new_val = ~(old_val & opnd);
      default:  write   = 1'b0;   // load and the unused codes
    endcase
    res.old_value = old_val;
    res.new_word  = (word & ~(mask << shamt)) | ((new_val & mask) << shamt);
    res.write     = write;
    res.success   = ok;
  end

endmodule

[hdl/atomic_read_modify_write_unit.sv]
// top level of the atomic read-modify-write unit over a 64-bit word store
//
// Atomic memory unit in front of a store of WORD_COUNT 64-bit words, addressed
// by byte, little-endian inside a word. Each request (load, store, exchange,
// compare-and-swap, fetch-add/sub/and/or/xor/nand on 1, 2, 4 or 8 bytes) gets
// exactly one response carrying the prior contents of the accessed bytes,
// zero-extended, and a success flag that is low only for a failed
// compare-and-swap. The address is aligned down to the access size and the
// word index wraps modulo WORD_COUNT. Codes ten to fifteen behave as a load.
// One request is in flight at a time: it takes a transfer cycle, a memory read
// cycle and a modify/write-back cycle, and the next request may be taken in
// that write-back cycle, so the unit sustains one request every two cycles
// while responses are drained; the figure is set by the one-cycle read latency
// of the word store in the read-modify-write loop. The store has no reset:
// reading bytes that were never written returns whatever the memory holds.
module atomic_read_modify_write_unit #(
  parameter int WORD_COUNT = 1024
) (
  input  logic      clk,
  input  logic      rst_n,
  rmw_req_if.sink   in_req,
  rmw_rsp_if.source out_rsp
);
  import rmw_pkg::*;

  localparam int IDX_W       = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
  // reciprocal for the word-index wrap; exact for every 10-bit index
  localparam int RECIP_SHIFT = 20;
  localparam int RECIP_W     = RECIP_SHIFT + 1;
  localparam int PROD_W      = WIDX_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'((2 ** RECIP_SHIFT + WORD_COUNT - 1) / WORD_COUNT);
  localparam logic [RECIP_W-1:0] DIVISOR = RECIP_W'(WORD_COUNT);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_MODIFY
  } state_t;

  state_t state_r;

  // request held for the access in flight
  logic [CMD_W-1:0]  cmd_r;
  logic [SIZE_W-1:0] size_r;
  logic [OFS_W-1:0]  ofs_r;
  logic [WIDX_W-1:0] widx_r;
  logic [WIDX_W-1:0] quot_r;
  logic [IDX_W-1:0]  idx_r;
  logic [DATA_W-1:0] operand_r;
  logic [DATA_W-1:0] expected_r;

  // response register
  logic              out_valid_r;
  logic [DATA_W-1:0] out_old_r;
  logic              out_success_r;

  logic [ADDR_W-1:0] aligned_addr;
  logic [PROD_W-1:0] quot_prod;
  logic [PROD_W-1:0] back_prod;
  logic [WIDX_W-1:0] rem_val;
  logic [IDX_W-1:0]  idx_comb;
  logic              out_free;
  logic              in_fire;
  logic              mem_rd_en;
  logic              mem_wr_en;
  logic [DATA_W-1:0] mem_rd_data;
  rmw_alu_res_t      alu_res;

  // response register can take a new value this cycle
  assign out_free = !out_valid_r || out_rsp.ready;

  // accept when idle, or while the current access retires into a free response slot
  assign in_req.ready = (state_r == ST_IDLE) || ((state_r == ST_MODIFY) && out_free);
  assign in_fire      = in_req.valid && in_req.ready;

  // natural alignment: clear the low address bits for the access size
  assign aligned_addr = in_req.byte_address &
                        ~ADDR_W'((1 << in_req.size_code) - 1);

  // quotient of word index by WORD_COUNT, registered before the back-multiply
  assign quot_prod = PROD_W'(aligned_addr[ADDR_W-1:OFS_W]) * PROD_W'(RECIP);

  // remainder is the wrapped word index, fits the low bits of the difference
  assign back_prod = PROD_W'(quot_r) * PROD_W'(DIVISOR);
  assign rem_val   = widx_r - back_prod[WIDX_W-1:0];
  assign idx_comb  = IDX_W'(rem_val);

  assign mem_rd_en = (state_r == ST_READ);
  assign mem_wr_en = (state_r == ST_MODIFY) && out_free && alu_res.write;

  rmw_mem #(
    .DEPTH (WORD_COUNT),
    .WIDTH (DATA_W),
    .ADDR_W(IDX_W)
  ) u_mem (
    .clk    (clk),
    .rd_en  (mem_rd_en),
    .rd_addr(idx_comb),
    .rd_data(mem_rd_data),
    .wr_en  (mem_wr_en),
    .wr_addr(idx_r),
    .wr_data(alu_res.new_word)
  );

  rmw_alu u_alu (
    .word          (mem_rd_data),
    .command       (cmd_r),
    .size_code     (size_r),
    .offset        (ofs_r),
    .operand_value (operand_r),
    .expected_value(expected_r),
    .res           (alu_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      // response slot fills on retire and drains on transfer
      if ((state_r == ST_MODIFY) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_rsp.ready) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            state_r <= ST_READ;
          end
        end
        ST_READ: begin
          idx_r   <= idx_comb;
          state_r <= ST_MODIFY;
        end
        ST_MODIFY: begin
          // retire only when the response slot is free, write-back goes with it
          if (out_free) begin
            out_old_r     <= alu_res.old_value;
            out_success_r <= alu_res.success;
            state_r       <= in_fire ? ST_READ : ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase

      if (in_fire) begin
        cmd_r      <= in_req.command;
        size_r     <= in_req.size_code;
        ofs_r      <= aligned_addr[OFS_W-1:0];
        widx_r     <= aligned_addr[ADDR_W-1:OFS_W];
        quot_r     <= quot_prod[RECIP_SHIFT+WIDX_W-1:RECIP_SHIFT];
        operand_r  <= in_req.operand_value;
        expected_r <= in_req.expected_value;
      end
    end
  end

  assign out_rsp.valid     = out_valid_r;
  assign out_rsp.old_value = out_old_r;
  assign out_rsp.success   = out_success_r;

  // a transferred request always moves on to the memory read
  a_fire_reads: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == ST_READ))
    else $error("accepted request did not start a memory read");

  // the store is written only while an access retires into a free response slot
  a_write_retires: assert property (@(posedge clk) disable iff (!rst_n)
    mem_wr_en |=> out_valid_r)
    else $error("store written without a response being produced");

  // the wrapped word index stays inside the store
  a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_READ) |-> (32'(idx_comb) < WORD_COUNT))
    else $error("word index beyond the store");

endmodule
